// File: rtl/core/brf_pkg.sv
// Shared types and constants for the black rectangle extent finder.
// Depends on nothing; the top level, brf_scan, brf_eval, the checker and the testbench import it.
package brf_pkg;

    localparam int CFG_DW = 7;
    localparam int CFG_AW = 1;

    localparam logic [CFG_AW-1:0] CFG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_COLS = 1'b1;
    localparam logic [CFG_DW-1:0] CFG_DIM_RESET  = 7'd64;

    localparam int NCRIT = 3;
    localparam logic [1:0] CRIT_HEIGHT = 2'd0;
    localparam logic [1:0] CRIT_WIDTH  = 2'd1;
    localparam logic [1:0] CRIT_AREA   = 2'd2;

    typedef struct packed {
        logic valid;
        logic close;
        logic opens;
        logic last_pixel;
    } t_evt_ctl;

endpackage

// File: rtl/core/brf_pix_if.sv
// Pixel stream channel: valid, ready and a one-bit pixel per beat.
// Depends on nothing.
interface brf_pix_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

// File: rtl/core/brf_res_if.sv
// Result channel: valid, ready and one rectangle report per beat.
// Depends on nothing.
interface brf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  criterion;
    logic        found;
    logic [5:0]  corner_row;
    logic [5:0]  corner_col;
    logic [6:0]  rect_height;
    logic [6:0]  rect_width;
    logic [12:0] rect_area;
    logic        last;

    modport source (output valid, output criterion, output found, output corner_row,
                    output corner_col, output rect_height, output rect_width,
                    output rect_area, output last, input ready);
    modport sink (input valid, input criterion, input found, input corner_row,
                  input corner_col, input rect_height, input rect_width,
                  input rect_area, input last, output ready);
endinterface

// File: rtl/core/black_rectangle_extent_finder.sv
// Black rectangle extent finder: takes one pixel per cycle in raster order and reports
// the first rectangle of largest height, width and area as three beats after the last
// pixel of each image. Sustained rate is one pixel per clock; a pixel passes a scan stage
// (one line-store read and write) and an evaluation stage (a small multiply and three
// compares), and the results are registered in a result buffer. Input stalls only while
// an image ends and the previous image's three beats have not all been taken.
// Depends on brf_pkg, brf_pix_if, brf_res_if, brf_scan and brf_eval.
module black_rectangle_extent_finder
    import brf_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    brf_pix_if.sink           i_pix,
    brf_res_if.source         o_res
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);

    logic [CFG_DW-1:0] r_rows, r_cols;
    t_evt_ctl          ev;
    logic              take;
    logic [IW-1:0]     ev_start, ev_row, rd_top;
    logic [CW-1:0]     ev_len, rd_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_DIM_RESET;
            r_cols <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_ROWS: r_rows <= i_cfg_wdata;
                CFG_IMAGE_COLS: r_cols <= i_cfg_wdata;
            endcase
        end
    end

    brf_scan #(.MAX_DIM(MAX_DIM)) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows_raw  (r_rows),
        .i_cols_raw  (r_cols),
        .i_pix_valid (i_pix.valid),
        .i_pixel     (i_pix.pixel),
        .o_pix_ready (i_pix.ready),
        .i_take      (take),
        .o_ev        (ev),
        .o_ev_start  (ev_start),
        .o_ev_row    (ev_row),
        .o_ev_len    (ev_len),
        .o_rd_top    (rd_top),
        .o_rd_width  (rd_width)
    );

    brf_eval #(.MAX_DIM(MAX_DIM)) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev       (ev),
        .i_ev_start (ev_start),
        .i_ev_row   (ev_row),
        .i_ev_len   (ev_len),
        .i_rd_top   (rd_top),
        .i_rd_width (rd_width),
        .o_take     (take),
        .o_res      (o_res)
    );

endmodule

// File: rtl/core/brf_scan.sv
// Raster scan front end: position counters, run tracking, the row of above
// bits and the per-column line store. Depends on brf_pkg.
module brf_scan
    import brf_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CFG_DW-1:0] i_rows_raw,
    input  logic [CFG_DW-1:0] i_cols_raw,
    input  logic              i_pix_valid,
    input  logic              i_pixel,
    output logic              o_pix_ready,
    input  logic              i_take,
    output t_evt_ctl          o_ev,
    output logic [$clog2(MAX_DIM)-1:0]   o_ev_start,
    output logic [$clog2(MAX_DIM)-1:0]   o_ev_row,
    output logic [$clog2(MAX_DIM+1)-1:0] o_ev_len,
    output logic [$clog2(MAX_DIM)-1:0]   o_rd_top,
    output logic [$clog2(MAX_DIM+1)-1:0] o_rd_width
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int FW = (CW > CFG_DW) ? CW : CFG_DW;

    function automatic logic [CW-1:0] clamp_dim(input logic [CFG_DW-1:0] raw);
        logic [FW-1:0] v;
        v = FW'(raw);
        if (v == '0) begin
            return CW'(1);
        end else if (v > FW'(MAX_DIM)) begin
            return CW'(MAX_DIM);
        end
        return CW'(v);
    endfunction

    logic [IW-1:0]      r_row, r_col, r_start, n_start;
    logic [CW-1:0]      r_len, n_len;
    logic               r_opens, n_opens;
    logic [MAX_DIM-1:0] r_above;
    t_evt_ctl           r_ev;

    logic [IW-1:0] mem_top [MAX_DIM];
    logic [CW-1:0] mem_width [MAX_DIM];

    logic [CW-1:0] rows, cols, col_inc, row_inc;
    logic          row_end, img_end, close, accept;

    always_comb begin
        rows    = clamp_dim(i_rows_raw);
        cols    = clamp_dim(i_cols_raw);
        col_inc = CW'(r_col) + CW'(1);
        row_inc = CW'(r_row) + CW'(1);
        row_end = col_inc >= cols;
        img_end = row_end && !(row_inc < rows);
        n_start = r_start;
        n_opens = r_opens;
        n_len   = r_len;
        if (i_pixel) begin
            if (r_len == '0) begin
                n_start = r_col;
                n_opens = !r_above[r_col];
            end
            if (r_len < CW'(MAX_DIM)) begin
                n_len = r_len + CW'(1);
            end
        end
        close = (n_len != '0) && (!i_pixel || row_end);
    end

    assign o_pix_ready = !r_ev.valid || i_take;
    assign accept      = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_opens <= 1'b0;
            r_above <= '0;
            r_ev    <= '0;
        end else begin
            if (i_take && !accept) begin
                r_ev.valid <= 1'b0;
            end
            if (accept) begin
                r_ev.valid      <= close || img_end;
                r_ev.close      <= close;
                r_ev.opens      <= n_opens;
                r_ev.last_pixel <= img_end;
                if (img_end) begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_start <= '0;
                    r_len   <= '0;
                    r_opens <= 1'b0;
                    r_above <= '0;
                end else begin
                    r_above[r_col] <= i_pixel;
                    r_start        <= n_start;
                    r_len          <= close ? '0 : n_len;
                    r_opens        <= close ? 1'b0 : n_opens;
                    if (row_end) begin
                        r_col <= '0;
                        r_row <= IW'(row_inc);
                    end else begin
                        r_col <= IW'(col_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_ev_start <= n_start;
            o_ev_row   <= r_row;
            o_ev_len   <= n_len;
            o_rd_top   <= mem_top[n_start];
            o_rd_width <= mem_width[n_start];
            if (close && n_opens) begin
                mem_top[n_start]   <= r_row;
                mem_width[n_start] <= n_len;
            end
        end
    end

    assign o_ev = r_ev;

endmodule

// File: rtl/core/brf_eval.sv
// Candidate evaluation, the three best-rectangle registers and the result
// buffer that plays out three beats per image. Depends on brf_pkg.
module brf_eval
    import brf_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_evt_ctl i_ev,
    input  logic [$clog2(MAX_DIM)-1:0]   i_ev_start,
    input  logic [$clog2(MAX_DIM)-1:0]   i_ev_row,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_ev_len,
    input  logic [$clog2(MAX_DIM)-1:0]   i_rd_top,
    input  logic [$clog2(MAX_DIM+1)-1:0] i_rd_width,
    output logic     o_take,
    brf_res_if.source o_res
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * CW;

    logic [IW-1:0] r_best_row [NCRIT], n_best_row [NCRIT];
    logic [IW-1:0] r_best_col [NCRIT], n_best_col [NCRIT];
    logic [CW-1:0] r_best_h [NCRIT], n_best_h [NCRIT];
    logic [CW-1:0] r_best_w [NCRIT], n_best_w [NCRIT];
    logic [AW-1:0] r_best_a [NCRIT], n_best_a [NCRIT];
    logic          r_found;

    logic [IW-1:0] r_snap_row [NCRIT], r_snap_col [NCRIT];
    logic [CW-1:0] r_snap_h [NCRIT], r_snap_w [NCRIT];
    logic [AW-1:0] r_snap_a [NCRIT];
    logic          r_snap_found, r_snap_valid;
    logic [1:0]    r_snap_idx;

    logic [IW-1:0] top;
    logic [CW-1:0] cand_h, cand_w;
    logic [AW-1:0] cand_a, key_c, key_b;

    always_comb begin
        top    = i_ev.opens ? i_ev_row : i_rd_top;
        cand_w = i_ev.opens ? i_ev_len : i_rd_width;
        if (top > i_ev_row) begin
            top = i_ev_row;
        end
        cand_h = CW'(i_ev_row) - CW'(top) + CW'(1);
        cand_a = AW'(cand_h) * AW'(cand_w);
        for (int k = 0; k < NCRIT; k++) begin
            n_best_row[k] = r_best_row[k];
            n_best_col[k] = r_best_col[k];
            n_best_h[k]   = r_best_h[k];
            n_best_w[k]   = r_best_w[k];
            n_best_a[k]   = r_best_a[k];
            unique case (2'(k))
                CRIT_HEIGHT: begin
                    key_c = AW'(cand_h);
                    key_b = AW'(r_best_h[k]);
                end
                CRIT_WIDTH: begin
                    key_c = AW'(cand_w);
                    key_b = AW'(r_best_w[k]);
                end
                default: begin
                    key_c = cand_a;
                    key_b = r_best_a[k];
                end
            endcase
            if (i_ev.close && key_c > key_b) begin
                n_best_row[k] = top;
                n_best_col[k] = i_ev_start;
                n_best_h[k]   = cand_h;
                n_best_w[k]   = cand_w;
                n_best_a[k]   = cand_a;
            end
        end
    end

    assign o_take = i_ev.valid && !(i_ev.last_pixel && r_snap_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found      <= 1'b0;
            r_snap_valid <= 1'b0;
            r_snap_idx   <= CRIT_HEIGHT;
            for (int k = 0; k < NCRIT; k++) begin
                r_best_row[k] <= '0;
                r_best_col[k] <= '0;
                r_best_h[k]   <= '0;
                r_best_w[k]   <= '0;
                r_best_a[k]   <= '0;
            end
        end else begin
            if (o_res.valid && o_res.ready) begin
                if (r_snap_idx == CRIT_AREA) begin
                    r_snap_valid <= 1'b0;
                end else begin
                    r_snap_idx <= r_snap_idx + 2'd1;
                end
            end
            if (o_take) begin
                if (i_ev.last_pixel) begin
                    r_snap_valid <= 1'b1;
                    r_snap_idx   <= CRIT_HEIGHT;
                    r_found      <= 1'b0;
                    for (int k = 0; k < NCRIT; k++) begin
                        r_best_row[k] <= '0;
                        r_best_col[k] <= '0;
                        r_best_h[k]   <= '0;
                        r_best_w[k]   <= '0;
                        r_best_a[k]   <= '0;
                    end
                end else begin
                    r_found <= r_found || i_ev.close;
                    for (int k = 0; k < NCRIT; k++) begin
                        r_best_row[k] <= n_best_row[k];
                        r_best_col[k] <= n_best_col[k];
                        r_best_h[k]   <= n_best_h[k];
                        r_best_w[k]   <= n_best_w[k];
                        r_best_a[k]   <= n_best_a[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ev.last_pixel) begin
            r_snap_found <= r_found || i_ev.close;
            for (int k = 0; k < NCRIT; k++) begin
                r_snap_row[k] <= n_best_row[k];
                r_snap_col[k] <= n_best_col[k];
                r_snap_h[k]   <= n_best_h[k];
                r_snap_w[k]   <= n_best_w[k];
                r_snap_a[k]   <= n_best_a[k];
            end
        end
    end

    assign o_res.valid       = r_snap_valid;
    assign o_res.criterion   = r_snap_idx;
    assign o_res.found       = r_snap_found;
    assign o_res.corner_row  = 6'(r_snap_row[r_snap_idx]);
    assign o_res.corner_col  = 6'(r_snap_col[r_snap_idx]);
    assign o_res.rect_height = 7'(r_snap_h[r_snap_idx]);
    assign o_res.rect_width  = 7'(r_snap_w[r_snap_idx]);
    assign o_res.rect_area   = 13'(r_snap_a[r_snap_idx]);
    assign o_res.last        = r_snap_idx == CRIT_AREA;

endmodule

// File: rtl/core/brf_checker.sv
// Port-level checks on the result channel of the extent finder, and the bind
// that attaches them to the top level. Depends on brf_pkg.
module brf_checker
    import brf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_criterion,
    input logic        i_found,
    input logic [6:0]  i_rect_height,
    input logic [6:0]  i_rect_width,
    input logic [12:0] i_rect_area,
    input logic        i_last
);

    a_last_on_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_criterion == CRIT_AREA)))
        else $error("last does not mark the area beat");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ready && !i_last) |=>
            (i_valid && i_criterion == $past(i_criterion) + 2'd1))
        else $error("result beats out of order");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_found) |->
            (i_rect_height == '0 && i_rect_width == '0 && i_rect_area == '0))
        else $error("nonzero extent reported with nothing found");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_criterion) && $stable(i_rect_area)))
        else $error("stalled result beat changed");

endmodule

bind black_rectangle_extent_finder brf_checker u_brf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_criterion   (o_res.criterion),
    .i_found       (o_res.found),
    .i_rect_height (o_res.rect_height),
    .i_rect_width  (o_res.rect_width),
    .i_rect_area   (o_res.rect_area),
    .i_last        (o_res.last)
);

// File: tb/black_rectangle_extent_finder_tb.sv
// Testbench for the black rectangle extent finder: streams binary images under many image
// sizes and checks every result beat against an in-bench scan model or a directed table.
// Depends on brf_pkg, brf_pix_if, brf_res_if and the black_rectangle_extent_finder RTL.
`timescale 1ns / 100ps

module black_rectangle_extent_finder_tb;
    import brf_pkg::*;

    localparam int MAX_DIM = 64;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [1:0] CRIT_ORDER [3] = '{CRIT_HEIGHT, CRIT_WIDTH, CRIT_AREA};
    localparam logic [6:0] EDGE_ROWS [6] = '{7'd0, 7'd5, 7'd1, 7'd3, 7'd0, 7'd2};
    localparam logic [6:0] EDGE_COLS [6] = '{7'd5, 7'd0, 7'd1, 7'd7, 7'd0, 7'd6};

    typedef struct packed {
        logic [1:0]  criterion;
        logic        found;
        logic [5:0]  corner_row;
        logic [5:0]  corner_col;
        logic [6:0]  rect_height;
        logic [6:0]  rect_width;
        logic [12:0] rect_area;
        logic        last;
    } t_report;

    typedef struct packed {
        logic [5:0]  row;
        logic [5:0]  col;
        logic [6:0]  height;
        logic [6:0]  width;
        logic [12:0] area;
    } t_extent;

    typedef struct {
        bit         cfg;
        logic [6:0] rows;
        logic [6:0] cols;
        bit         px;
        bit         typed;
    } t_pixel_step;

    typedef enum {
        IMG_RECTS,
        IMG_BROKEN,
        IMG_NOISE,
        IMG_BLACK,
        IMG_WHITE,
        IMG_CORNER_DOT
    } t_image_kind;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;

    brf_pix_if pix_if ();
    brf_res_if res_if ();

    black_rectangle_extent_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if),
        .o_res       (res_if)
    );

    // Scan model state.
    logic [6:0]  rows_reg;
    logic [6:0]  cols_reg;
    bit          above_bits [MAX_DIM];
    logic [5:0]  top_row_mem [MAX_DIM];
    logic [6:0]  width_mem [MAX_DIM];
    bit          col_written [MAX_DIM];
    int          scan_row;
    int          scan_col;
    int          run_col;
    int          run_len;
    bit          run_opens;
    t_extent     best_extent [3];
    bit          any_found;

    t_report     expected_reports [$];
    int          mismatch_count;
    int          sender_gap_pct;
    int          receiver_stall_pct;
    bit          canvas [MAX_DIM][MAX_DIM];

    // Single-pixel images (one row, one column) carry their expected beats in the table.
    t_pixel_step directed_steps [22] = '{
        '{1'b1, 7'd0, 7'd0, 1'b0, 1'b1},
        '{1'b0, 7'd0, 7'd0, 1'b1, 1'b1},
        '{1'b0, 7'd0, 7'd0, 1'b1, 1'b1},
        '{1'b0, 7'd0, 7'd0, 1'b0, 1'b1},
        '{1'b1, 7'd1, 7'd1, 1'b1, 1'b1},
        '{1'b0, 7'd1, 7'd1, 1'b0, 1'b1},
        '{1'b1, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd3, 1'b1, 1'b0},
        '{1'b1, 7'd2, 7'd2, 1'b1, 1'b0},
        '{1'b0, 7'd2, 7'd2, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd2, 1'b0, 1'b0},
        '{1'b0, 7'd2, 7'd2, 1'b1, 1'b0}
    };

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int dim_of(input logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic void clear_image();
        foreach (above_bits[i]) above_bits[i] = 1'b0;
        scan_row = 0;
        scan_col = 0;
        run_col = 0;
        run_len = 0;
        run_opens = 1'b0;
        foreach (best_extent[i]) best_extent[i] = '0;
        any_found = 1'b0;
    endfunction

    function automatic int scan_pixel(input bit px, output t_report rep [3]);
        int      rows_n;
        int      cols_n;
        int      c;
        int      r;
        int      top;
        bit      row_end;
        t_extent cand;
        foreach (rep[k]) rep[k] = '0;
        rows_n = dim_of(rows_reg);
        cols_n = dim_of(cols_reg);
        c = scan_col;
        r = scan_row;
        row_end = (c + 1 >= cols_n);
        if (px) begin
            if (run_len == 0) begin
                run_col = c;
                run_opens = !above_bits[c];
            end
            if (run_len < MAX_DIM) run_len++;
        end
        above_bits[c] = px;
        if (run_len > 0 && (!px || row_end)) begin
            if (run_opens) begin
                top_row_mem[run_col] = r[5:0];
                width_mem[run_col] = run_len[6:0];
                col_written[run_col] = 1'b1;
            end
            top = top_row_mem[run_col];
            if (top > r) top = r;
            cand.row = top[5:0];
            cand.col = run_col[5:0];
            cand.height = 7'(r - top + 1);
            cand.width = width_mem[run_col];
            cand.area = cand.height * cand.width;
            if (cand.height > best_extent[CRIT_HEIGHT].height) best_extent[CRIT_HEIGHT] = cand;
            if (cand.width > best_extent[CRIT_WIDTH].width) best_extent[CRIT_WIDTH] = cand;
            if (cand.area > best_extent[CRIT_AREA].area) best_extent[CRIT_AREA] = cand;
            any_found = 1'b1;
            run_len = 0;
            run_opens = 1'b0;
        end
        if (!row_end) begin
            scan_col = c + 1;
            return 0;
        end
        scan_col = 0;
        if (r + 1 < rows_n) begin
            scan_row = r + 1;
            return 0;
        end
        for (int k = 0; k < 3; k++) begin
            rep[k].criterion = CRIT_ORDER[k];
            rep[k].found = any_found;
            rep[k].corner_row = best_extent[CRIT_ORDER[k]].row;
            rep[k].corner_col = best_extent[CRIT_ORDER[k]].col;
            rep[k].rect_height = best_extent[CRIT_ORDER[k]].height;
            rep[k].rect_width = best_extent[CRIT_ORDER[k]].width;
            rep[k].rect_area = best_extent[CRIT_ORDER[k]].area;
            rep[k].last = (k == 2);
        end
        clear_image();
        return 3;
    endfunction

    task automatic send_pixel(input bit px, input bit typed);
        t_report rep [3];
        int      n;
        while ($urandom_range(99) < sender_gap_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        n = scan_pixel(px, rep);
        for (int k = 0; k < n; k++) begin
            if (typed) begin
                rep[k].criterion = CRIT_ORDER[k];
                rep[k].found = px;
                rep[k].corner_row = 6'd0;
                rep[k].corner_col = 6'd0;
                rep[k].rect_height = px ? 7'd1 : 7'd0;
                rep[k].rect_width = px ? 7'd1 : 7'd0;
                rep[k].rect_area = px ? 13'd1 : 13'd0;
                rep[k].last = (k == 2);
            end
            expected_reports.push_back(rep[k]);
        end
    endtask

    task automatic send_image(input t_image_kind kind);
        int rows_n;
        int cols_n;
        int h;
        int w;
        int r0;
        int c0;
        int fr;
        int fc;
        bit clear;
        bit px;
        rows_n = dim_of(rows_reg);
        cols_n = dim_of(cols_reg);
        foreach (canvas[r, c]) canvas[r][c] = (kind == IMG_BLACK);
        if (kind == IMG_CORNER_DOT) canvas[rows_n-1][cols_n-1] = 1'b1;
        if (kind == IMG_RECTS || kind == IMG_BROKEN) begin
            repeat ($urandom_range(1, 6)) begin
                h = $urandom_range(1, rows_n);
                w = $urandom_range(1, cols_n);
                r0 = $urandom_range(0, rows_n - h);
                c0 = $urandom_range(0, cols_n - w);
                clear = 1'b1;
                for (int r = r0 - 1; r <= r0 + h; r++) begin
                    for (int c = c0 - 1; c <= c0 + w; c++) begin
                        if (r >= 0 && r < rows_n && c >= 0 && c < cols_n && canvas[r][c])
                            clear = 1'b0;
                    end
                end
                if (clear) begin
                    for (int r = r0; r < r0 + h; r++) begin
                        for (int c = c0; c < c0 + w; c++) canvas[r][c] = 1'b1;
                    end
                end
            end
        end
        if (kind == IMG_BROKEN) begin
            repeat ($urandom_range(1, 4)) begin
                fr = $urandom_range(0, rows_n - 1);
                fc = $urandom_range(0, cols_n - 1);
                canvas[fr][fc] = !canvas[fr][fc];
            end
        end
        if (kind == IMG_NOISE) begin
            for (int r = 0; r < rows_n; r++) begin
                for (int c = 0; c < cols_n; c++) canvas[r][c] = ($urandom_range(99) < 45);
            end
        end
        for (int r = 0; r < rows_n; r++) begin
            for (int c = 0; c < cols_n; c++) begin
                px = canvas[r][c];
                // A run must not continue under a column whose line-store entry was never set.
                if (px && run_len == 0 && above_bits[c] && !col_written[c]) px = 1'b0;
                send_pixel(px, 1'b0);
            end
        end
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [6:0] rows, input logic [6:0] cols);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_IMAGE_ROWS;
        i_cfg_wdata <= rows;
        @(posedge i_clk);
        i_cfg_addr <= CFG_IMAGE_COLS;
        i_cfg_wdata <= cols;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rows_reg = rows;
        cols_reg = cols;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{criterion: res_if.criterion, found: res_if.found,
                    corner_row: res_if.corner_row, corner_col: res_if.corner_col,
                    rect_height: res_if.rect_height, rect_width: res_if.rect_width,
                    rect_area: res_if.rect_area, last: res_if.last};
            if (expected_reports.size() == 0) begin
                $display("%0t: result beat mismatch, expected none, got %p", $time, got);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("criterion", want.criterion, got.criterion);
                check_field("found", want.found, got.found);
                check_field("corner_row", want.corner_row, got.corner_row);
                check_field("corner_col", want.corner_col, got.corner_col);
                check_field("rect_height", want.rect_height, got.rect_height);
                check_field("rect_width", want.rect_width, got.rect_width);
                check_field("rect_area", want.rect_area, got.rect_area);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int          phase;
        int          images_sent;
        int          roll;
        t_image_kind kind;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = CFG_IMAGE_ROWS;
        i_cfg_wdata = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = 1'b0;
        mismatch_count = 0;
        sender_gap_pct = 17;
        receiver_stall_pct = 85;
        rows_reg = CFG_DIM_RESET;
        cols_reg = CFG_DIM_RESET;
        foreach (top_row_mem[i]) top_row_mem[i] = '0;
        foreach (width_mem[i]) width_mem[i] = '0;
        foreach (col_written[i]) col_written[i] = 1'b0;
        clear_image();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].cfg) begin
                settle();
                set_dims(directed_steps[i].rows, directed_steps[i].cols);
            end
            send_pixel(directed_steps[i].px, directed_steps[i].typed);
        end

        phase = 0;
        images_sent = 0;
        while (phase < 18 || images_sent < 16) begin
            if (phase < 6) begin
                sender_gap_pct = 17;
                receiver_stall_pct = 85;
            end else if (phase < 12) begin
                sender_gap_pct = 85;
                receiver_stall_pct = 17;
            end else begin
                sender_gap_pct = 0;
                receiver_stall_pct = 0;
            end
            settle();
            if (phase < 18 && phase % 3 == 0) begin
                set_dims(EDGE_ROWS[phase / 3], EDGE_COLS[phase / 3]);
            end else begin
                set_dims(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
            end
            repeat ((phase % 3 == 0) ? 1 : $urandom_range(1, 2)) begin
                roll = $urandom_range(9);
                case (roll)
                    0, 1, 2, 3, 4: kind = IMG_RECTS;
                    5, 6: kind = IMG_BROKEN;
                    7, 8: kind = IMG_NOISE;
                    default: begin
                        if ($urandom_range(1) == 1) kind = IMG_BLACK;
                        else kind = IMG_WHITE;
                    end
                endcase
                send_image(kind);
                images_sent++;
            end
            phase++;
        end

        // Oversized register values clamp to one full column and one full row, which reach
        // the largest height and width.
        settle();
        set_dims(7'd127, 7'd1);
        send_image(IMG_BLACK);
        settle();
        set_dims(7'd1, 7'd127);
        send_image(IMG_BLACK);
        settle();
        set_dims(7'd2, 7'd3);
        send_image(IMG_CORNER_DOT);

        settle();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/brf_pkg.sv
rtl/core/brf_pix_if.sv
rtl/core/brf_res_if.sv
rtl/core/brf_scan.sv
rtl/core/brf_eval.sv
rtl/core/black_rectangle_extent_finder.sv
rtl/core/brf_checker.sv
tb/black_rectangle_extent_finder_tb.sv
